// File: design/rgb_pixel_fade_engine_macros.svh
// Assertion macros shared by the fade engine modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef RGB_PIXEL_FADE_ENGINE_MACROS_SVH
`define RGB_PIXEL_FADE_ENGINE_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define RGBFE_ASSERT_SAME(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define RGBFE_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);

`endif

// File: design/rgbfe_pkg.sv
// Shared constants of the RGB pixel fade engine.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package rgbfe_pkg;

    localparam int PIXELS_DEF    = 16;
    localparam int STEP_BITS_DEF = 16;

    localparam logic [2:0] REQ_SET     = 3'd0;
    localparam logic [2:0] REQ_SETUP   = 3'd1;
    localparam logic [2:0] REQ_REVERSE = 3'd2;
    localparam logic [2:0] REQ_EXECUTE = 3'd3;
    localparam logic [2:0] REQ_READ    = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_PIXEL = 2'd1;
    localparam logic [1:0] ST_BAD_STEPS = 2'd2;

    localparam logic [1:0] FS_IDLE   = 2'd0;
    localparam logic [1:0] FS_ACTIVE = 2'd1;
    localparam logic [1:0] FS_ERROR  = 2'd2;

endpackage

// File: design/rgb_pixel_fade_engine.sv
// Top level of the RGB pixel fade engine: request sequencer and pixel state.
// Depends on rgbfe_pkg, rgbfe_pixel_mem, rgbfe_muldiv and the macro header.
//
// A transfer is taken when start is high and busy is low; its single result
// appears for exactly one cycle with done high and must be captured then, as
// the engine cannot be held off. Busy stays high until the cycle after done.
// done comes from S_RESP, reached via S_LOAD, S_APPLY and S_WR for set,
// reverse and a valid setup, via S_LOAD and S_APPLY only for read, an unknown
// request, a rejected setup and an execute on an idle pixel, and straight from
// S_IDLE for a bad pixel index. An execute step runs the shared bit-serial
// multiply-divide once for each channel still away from its target while the
// step total is nonzero; each pass shifts in eight multiply bits and then
// STEP_BITS + 9 quotient bits, and a zero total sets the channel to its target.
`timescale 1ns / 1ps
`include "rgb_pixel_fade_engine_macros.svh"

module rgb_pixel_fade_engine #(
    parameter int PIXELS    = rgbfe_pkg::PIXELS_DEF,
    parameter int STEP_BITS = rgbfe_pkg::STEP_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  req_type,
    input  logic [7:0]  pixel,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [7:0]  start_red,
    input  logic [7:0]  start_green,
    input  logic [7:0]  start_blue,
    input  logic        has_start,
    input  logic [15:0] step_count,
    input  logic [15:0] first_step,
    input  logic        fade_mode,
    output logic        done,
    output logic [1:0]  status,
    output logic [1:0]  fade_state,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue
);

    localparam int PIX_W  = PIXELS > 1 ? $clog2(PIXELS) : 1;
    localparam int SB     = STEP_BITS;
    localparam int O_ST   = 24;
    localparam int O_TG   = 48;
    localparam int O_HD   = 72;
    localparam int O_TOT  = 96;
    localparam int O_STP  = O_TOT + SB;
    localparam int O_CONT = O_STP + SB + 1;
    localparam int O_ACT  = O_CONT + 1;
    localparam int REC_W  = O_ACT + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_APPLY,
        S_CH,
        S_WAIT,
        S_NEXT,
        S_FIN,
        S_WR,
        S_RESP
    } state_t;

    state_t          state_reg;
    state_t          state_next;

    logic [2:0]      req_reg;
    logic [7:0]      pix_reg;
    logic [7:0]      in_reg [3];
    logic [7:0]      sin_reg [3];
    logic            has_reg;
    logic [15:0]     steps_reg;
    logic [15:0]     first_reg;
    logic            mode_reg;
    logic            bad_reg;
    logic [1:0]      status_reg;

    logic [7:0]      cur_reg [3];
    logic [7:0]      st_reg [3];
    logic [7:0]      tg_reg [3];
    logic [7:0]      hd_reg [3];
    logic [SB-1:0]   tot_reg;
    logic [SB:0]     stp_reg;
    logic            act_reg;
    logic            cont_reg;
    logic [1:0]      ch_reg;
    logic [1:0]      cnt_done_reg;

    logic            accept;
    logic            pix_bad;
    logic            bad_steps;
    logic [SB:0]     stp_inc;
    logic [SB:0]     tot_ext;
    logic [REC_W-1:0] rd_rec;
    logic [REC_W-1:0] wr_rec;
    logic            mem_we;
    logic            unit_go;
    logic            unit_ready;
    logic [7:0]      unit_quot;
    logic            neg;
    logic [7:0]      mag;
    logic [7:0]      new_val;

    assign accept    = start && !busy;
    assign busy      = state_reg != S_IDLE;
    assign pix_bad   = {1'b0, pixel} >= 9'(PIXELS);
    assign bad_steps = (steps_reg == 16'd0) || (first_reg >= steps_reg)
                       || ((32'(steps_reg) >> SB) != 32'd0);
    assign tot_ext   = {1'b0, tot_reg};
    assign stp_inc   = (&stp_reg) ? stp_reg : stp_reg + (SB + 1)'(1);
    assign neg       = tg_reg[ch_reg] < st_reg[ch_reg];
    assign mag       = neg ? st_reg[ch_reg] - tg_reg[ch_reg] : tg_reg[ch_reg] - st_reg[ch_reg];
    assign new_val   = neg ? st_reg[ch_reg] - unit_quot : st_reg[ch_reg] + unit_quot;
    assign unit_go   = (state_reg == S_CH) && (cur_reg[ch_reg] != tg_reg[ch_reg])
                       && (tot_reg != '0);
    assign mem_we    = state_reg == S_WR;

    assign wr_rec = {act_reg, cont_reg, stp_reg, tot_reg,
                     hd_reg[2], hd_reg[1], hd_reg[0],
                     tg_reg[2], tg_reg[1], tg_reg[0],
                     st_reg[2], st_reg[1], st_reg[0],
                     cur_reg[2], cur_reg[1], cur_reg[0]};

    rgbfe_pixel_mem #(
        .PIXELS (PIXELS),
        .DATA_W (REC_W)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (pix_reg[PIX_W-1:0]),
        .wdata (wr_rec),
        .re    (accept),
        .raddr (pixel[PIX_W-1:0]),
        .rdata (rd_rec)
    );

    rgbfe_muldiv #(
        .STEP_BITS (STEP_BITS)
    ) u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (unit_go),
        .step  (stp_reg),
        .mag   (mag),
        .total (tot_reg),
        .ready (unit_ready),
        .quot  (unit_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (accept) state_next = pix_bad ? S_RESP : S_LOAD;
            S_LOAD:
                state_next = S_APPLY;
            S_APPLY:
            begin
                case (req_reg) inside
                    rgbfe_pkg::REQ_SET, rgbfe_pkg::REQ_REVERSE: state_next = S_WR;
                    rgbfe_pkg::REQ_SETUP: state_next = bad_steps ? S_RESP : S_WR;
                    rgbfe_pkg::REQ_EXECUTE: state_next = act_reg ? S_CH : S_RESP;
                    default: state_next = S_RESP;
                endcase
            end
            S_CH:
                state_next = unit_go ? S_WAIT : S_NEXT;
            S_WAIT:
                if (unit_ready) state_next = S_NEXT;
            S_NEXT:
                state_next = (ch_reg == 2'd2) ? S_FIN : S_CH;
            S_FIN:
                state_next = S_WR;
            S_WR:
                state_next = S_RESP;
            S_RESP:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_reg    <= req_type;
                    pix_reg    <= pixel;
                    in_reg[0]  <= red;
                    in_reg[1]  <= green;
                    in_reg[2]  <= blue;
                    sin_reg[0] <= start_red;
                    sin_reg[1] <= start_green;
                    sin_reg[2] <= start_blue;
                    has_reg    <= has_start;
                    steps_reg  <= step_count;
                    first_reg  <= first_step;
                    mode_reg   <= fade_mode;
                    bad_reg    <= pix_bad;
                    status_reg <= pix_bad ? rgbfe_pkg::ST_BAD_PIXEL : rgbfe_pkg::ST_OK;
                end
            end
            S_LOAD:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    cur_reg[c] <= rd_rec[c*8 +: 8];
                    st_reg[c]  <= rd_rec[O_ST + c*8 +: 8];
                    tg_reg[c]  <= rd_rec[O_TG + c*8 +: 8];
                    hd_reg[c]  <= rd_rec[O_HD + c*8 +: 8];
                end
                tot_reg  <= rd_rec[O_TOT +: SB];
                stp_reg  <= rd_rec[O_STP +: SB + 1];
                cont_reg <= rd_rec[O_CONT];
                act_reg  <= rd_rec[O_ACT];
            end
            S_APPLY:
            begin
                ch_reg       <= 2'd0;
                cnt_done_reg <= 2'd0;
                case (req_reg)
                    rgbfe_pkg::REQ_SET:
                    begin
                        for (int c = 0; c < 3; c++)
                        begin
                            cur_reg[c] <= in_reg[c];
                        end
                        act_reg <= 1'b0;
                    end
                    rgbfe_pkg::REQ_SETUP:
                    begin
                        if (bad_steps)
                        begin
                            status_reg <= rgbfe_pkg::ST_BAD_STEPS;
                        end
                        else
                        begin
                            for (int c = 0; c < 3; c++)
                            begin
                                tg_reg[c] <= has_reg ? sin_reg[c] : in_reg[c];
                                hd_reg[c] <= has_reg ? in_reg[c] : cur_reg[c];
                                st_reg[c] <= cur_reg[c];
                            end
                            tot_reg  <= SB'(32'(steps_reg));
                            stp_reg  <= (SB + 1)'(32'(first_reg));
                            act_reg  <= 1'b1;
                            cont_reg <= mode_reg;
                        end
                    end
                    rgbfe_pkg::REQ_REVERSE:
                    begin
                        for (int c = 0; c < 3; c++)
                        begin
                            hd_reg[c] <= tg_reg[c];
                            tg_reg[c] <= st_reg[c];
                            st_reg[c] <= tg_reg[c];
                        end
                        stp_reg <= (tot_ext >= stp_reg) ? tot_ext - stp_reg : '0;
                        act_reg <= 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_CH:
            begin
                if (cur_reg[ch_reg] == tg_reg[ch_reg])
                begin
                    cnt_done_reg <= cnt_done_reg + 2'd1;
                end
                else if (tot_reg == '0)
                begin
                    cur_reg[ch_reg] <= tg_reg[ch_reg];
                end
            end
            S_WAIT:
            begin
                if (unit_ready)
                begin
                    cur_reg[ch_reg] <= new_val;
                end
            end
            S_NEXT:
            begin
                ch_reg <= ch_reg + 2'd1;
            end
            S_FIN:
            begin
                stp_reg <= stp_inc;
                if (cnt_done_reg == 2'd3)
                begin
                    if (!cont_reg)
                    begin
                        act_reg <= 1'b0;
                    end
                    else
                    begin
                        for (int c = 0; c < 3; c++)
                        begin
                            hd_reg[c] <= tg_reg[c];
                            tg_reg[c] <= hd_reg[c];
                            st_reg[c] <= tg_reg[c];
                        end
                        stp_reg <= (tot_ext >= stp_inc) ? tot_ext - stp_inc : '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done       = state_reg == S_RESP;
    assign status     = status_reg;
    assign fade_state = bad_reg ? rgbfe_pkg::FS_ERROR
                      : (act_reg ? rgbfe_pkg::FS_ACTIVE : rgbfe_pkg::FS_IDLE);
    assign out_red    = bad_reg ? 8'd0 : cur_reg[0];
    assign out_green  = bad_reg ? 8'd0 : cur_reg[1];
    assign out_blue   = bad_reg ? 8'd0 : cur_reg[2];

    `RGBFE_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy,
        "Engine not busy after a transfer was accepted")
    `RGBFE_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done,
        "Result strobe held for more than one cycle")
    `RGBFE_ASSERT_SAME(a_write_good_pixel, clk, rst_n, mem_we, !bad_reg,
        "Pixel store written for an out-of-range pixel")
    `RGBFE_ASSERT_SAME(a_unit_idle_wait, clk, rst_n, state_reg == S_WAIT, !unit_go,
        "Divider started while a channel result is pending")

endmodule

// File: design/rgbfe_muldiv.sv
// Bit-serial multiply and restoring divide: floor(step * mag / total), low byte.
// Uses rgbfe_pkg only for defaults; instantiated by the top level.
`timescale 1ns / 1ps

module rgbfe_muldiv #(
    parameter int STEP_BITS = rgbfe_pkg::STEP_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 go,
    input  logic [STEP_BITS:0]   step,
    input  logic [7:0]           mag,
    input  logic [STEP_BITS-1:0] total,
    output logic                 ready,
    output logic [7:0]           quot
);

    localparam int PW  = STEP_BITS + 9;
    localparam int CW  = $clog2(PW + 1);

    typedef enum logic [1:0] {
        U_IDLE,
        U_MUL,
        U_DIV
    } ustate_t;

    ustate_t              state_reg;
    ustate_t              state_next;
    logic [CW-1:0]        cnt_reg;
    logic [PW-1:0]        prod_reg;
    logic [7:0]           mag_reg;
    logic [STEP_BITS:0]   step_reg;
    logic [STEP_BITS-1:0] tot_reg;
    logic [STEP_BITS-1:0] rem_reg;
    logic [7:0]           quot_reg;
    logic                 ready_reg;
    logic [STEP_BITS:0]   rem_shift;
    logic                 qbit;

    assign rem_shift = {rem_reg, prod_reg[PW-1]};
    assign qbit      = rem_shift >= {1'b0, tot_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            U_IDLE: if (go) state_next = U_MUL;
            U_MUL:  if (cnt_reg == CW'(7)) state_next = U_DIV;
            U_DIV:  if (cnt_reg == CW'(PW - 1)) state_next = U_IDLE;
            default: state_next = U_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_reg == U_DIV) && (cnt_reg == CW'(PW - 1));
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            U_IDLE:
            begin
                cnt_reg  <= '0;
                prod_reg <= '0;
                rem_reg  <= '0;
                mag_reg  <= mag;
                step_reg <= step;
                tot_reg  <= total;
            end
            U_MUL:
            begin
                prod_reg <= (prod_reg << 1) + (mag_reg[7] ? PW'(step_reg) : '0);
                mag_reg  <= mag_reg << 1;
                cnt_reg  <= (cnt_reg == CW'(7)) ? '0 : cnt_reg + CW'(1);
            end
            U_DIV:
            begin
                rem_reg  <= qbit ? STEP_BITS'(rem_shift - {1'b0, tot_reg})
                                 : STEP_BITS'(rem_shift);
                prod_reg <= prod_reg << 1;
                quot_reg <= {quot_reg[6:0], qbit};
                cnt_reg  <= cnt_reg + CW'(1);
            end
            default: cnt_reg <= '0;
        endcase
    end

    assign ready = ready_reg;
    assign quot  = quot_reg;

endmodule

// File: design/rgbfe_pixel_mem.sv
// Per-pixel record store: one write and one registered read port per cycle.
// Valid flags make a never-written entry read as zero. Uses rgbfe_pkg defaults.
`timescale 1ns / 1ps

module rgbfe_pixel_mem #(
    parameter int PIXELS = rgbfe_pkg::PIXELS_DEF,
    parameter int DATA_W = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 we,
    input  logic [(PIXELS > 1 ? $clog2(PIXELS) : 1)-1:0] waddr,
    input  logic [DATA_W-1:0]                    wdata,
    input  logic                                 re,
    input  logic [(PIXELS > 1 ? $clog2(PIXELS) : 1)-1:0] raddr,
    output logic [DATA_W-1:0]                    rdata
);

    logic [DATA_W-1:0] mem [PIXELS];
    logic [PIXELS-1:0] valid_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic              rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rvalid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

// File: tb/sv/rgbfe_fade_checker.sv
// Checker for the RGB pixel fade engine: models the pixel table and compares every result.
// Depends on rgbfe_pkg; instantiated beside the engine by tb_top.
`timescale 1ns / 1ps

module rgbfe_fade_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  req_type,
    input  logic [7:0]  pixel,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [7:0]  start_red,
    input  logic [7:0]  start_green,
    input  logic [7:0]  start_blue,
    input  logic        has_start,
    input  logic [15:0] step_count,
    input  logic [15:0] first_step,
    input  logic        fade_mode,
    input  logic        done,
    input  logic [1:0]  status,
    input  logic [1:0]  fade_state,
    input  logic [7:0]  out_red,
    input  logic [7:0]  out_green,
    input  logic [7:0]  out_blue,
    output int          fail_count,
    output int          pending
);

    localparam int NPIX = rgbfe_pkg::PIXELS_DEF;
    localparam logic [16:0] STEP_SAT = '1;

    typedef logic [7:0] rgb_t [3];

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] fade_state;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pixel_answer_t;

    rgb_t        cur_col [NPIX];
    rgb_t        src_col [NPIX];
    rgb_t        dst_col [NPIX];
    rgb_t        hold_col [NPIX];
    logic [15:0] total_of [NPIX];
    logic [16:0] step_of [NPIX];
    logic        active_of [NPIX];
    logic        cont_of [NPIX];

    pixel_answer_t answers_due [$];

    function automatic void reverse_fade(int p);
        hold_col[p] = dst_col[p];
        dst_col[p]  = src_col[p];
        src_col[p]  = hold_col[p];
        if ({1'b0, total_of[p]} >= step_of[p])
            step_of[p] = {1'b0, total_of[p]} - step_of[p];
        else
            step_of[p] = '0;
        active_of[p] = 1'b1;
    endfunction

    function automatic void fade_step(int p);
        int     matched;
        longint diff;
        longint quot;
        matched = 0;
        if (!active_of[p])
            return;
        for (int c = 0; c < 3; c++)
        begin
            if (cur_col[p][c] == dst_col[p][c])
                matched++;
            else if (total_of[p] == 0)
                cur_col[p][c] = dst_col[p][c];
            else
            begin
                diff = longint'(dst_col[p][c]) - longint'(src_col[p][c]);
                quot = (longint'(step_of[p]) * diff) / longint'(total_of[p]);
                cur_col[p][c] = 8'(longint'(src_col[p][c]) + quot);
            end
        end
        if (step_of[p] < STEP_SAT)
            step_of[p]++;
        if (matched == 3)
        begin
            if (!cont_of[p])
                active_of[p] = 1'b0;
            else
            begin
                src_col[p] = hold_col[p];
                reverse_fade(p);
            end
        end
    endfunction

    function automatic pixel_answer_t predict_request();
        pixel_answer_t a;
        int            p;
        logic [1:0]    st;
        st = rgbfe_pkg::ST_OK;
        if (pixel >= NPIX)
        begin
            a = '{rgbfe_pkg::ST_BAD_PIXEL, rgbfe_pkg::FS_ERROR, 8'd0, 8'd0, 8'd0};
            return a;
        end
        p = pixel;
        case (req_type)
            rgbfe_pkg::REQ_SET:
            begin
                cur_col[p] = '{red, green, blue};
                active_of[p] = 1'b0;
            end
            rgbfe_pkg::REQ_SETUP:
            begin
                if (step_count == 0 || first_step >= step_count)
                    st = rgbfe_pkg::ST_BAD_STEPS;
                else
                begin
                    if (!has_start)
                    begin
                        dst_col[p]  = '{red, green, blue};
                        hold_col[p] = cur_col[p];
                    end
                    else
                    begin
                        dst_col[p]  = '{start_red, start_green, start_blue};
                        hold_col[p] = '{red, green, blue};
                    end
                    src_col[p]   = cur_col[p];
                    total_of[p]  = step_count;
                    step_of[p]   = {1'b0, first_step};
                    active_of[p] = 1'b1;
                    cont_of[p]   = fade_mode;
                end
            end
            rgbfe_pkg::REQ_REVERSE: reverse_fade(p);
            rgbfe_pkg::REQ_EXECUTE: fade_step(p);
            default: ;
        endcase
        a.status     = st;
        a.fade_state = active_of[p] ? rgbfe_pkg::FS_ACTIVE : rgbfe_pkg::FS_IDLE;
        a.r = cur_col[p][0];
        a.g = cur_col[p][1];
        a.b = cur_col[p][2];
        return a;
    endfunction

    always @(posedge clk)
    begin
        pixel_answer_t e;
        if (!rst_n)
        begin
            for (int p = 0; p < NPIX; p++)
            begin
                cur_col[p]   = '{8'd0, 8'd0, 8'd0};
                src_col[p]   = '{8'd0, 8'd0, 8'd0};
                dst_col[p]   = '{8'd0, 8'd0, 8'd0};
                hold_col[p]  = '{8'd0, 8'd0, 8'd0};
                total_of[p]  = '0;
                step_of[p]   = '0;
                active_of[p] = 1'b0;
                cont_of[p]   = 1'b0;
            end
            answers_due.delete();
        end
        else
        begin
            if (done)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    e = answers_due.pop_front();
                    if (status !== e.status)
                    begin
                        $error("status: expected %0d, got %0d", e.status, status);
                        fail_count++;
                    end
                    if (fade_state !== e.fade_state)
                    begin
                        $error("fade_state: expected %0d, got %0d", e.fade_state, fade_state);
                        fail_count++;
                    end
                    if (out_red !== e.r)
                    begin
                        $error("out_red: expected %0d, got %0d", e.r, out_red);
                        fail_count++;
                    end
                    if (out_green !== e.g)
                    begin
                        $error("out_green: expected %0d, got %0d", e.g, out_green);
                        fail_count++;
                    end
                    if (out_blue !== e.b)
                    begin
                        $error("out_blue: expected %0d, got %0d", e.b, out_blue);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                answers_due.push_back(predict_request());
        end
        pending <= answers_due.size();
    end

endmodule

// File: tb/sv/tb_top.sv
// Top of the fade engine testbench: clock, reset, request stimulus and verdict.
// Depends on rgbfe_pkg, rgb_pixel_fade_engine and rgbfe_fade_checker.
`timescale 1ns / 1ps

module tb_top;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  req_type = rgbfe_pkg::REQ_READ;
    logic [7:0]  pixel = '0;
    logic [7:0]  red = '0;
    logic [7:0]  green = '0;
    logic [7:0]  blue = '0;
    logic [7:0]  start_red = '0;
    logic [7:0]  start_green = '0;
    logic [7:0]  start_blue = '0;
    logic        has_start = 1'b0;
    logic [15:0] step_count = '0;
    logic [15:0] first_step = '0;
    logic        fade_mode = 1'b0;
    logic        done;
    logic [1:0]  status;
    logic [1:0]  fade_state;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    int          fail_count;
    int          pending;

    always #4 clk = ~clk;

    rgb_pixel_fade_engine uut (.*);

    rgbfe_fade_checker chk (.*);

    task automatic issue(input logic [2:0] rq, input logic [7:0] px,
                         input logic [23:0] col, input logic [23:0] first_col,
                         input logic hs, input logic [15:0] cnt,
                         input logic [15:0] fst, input logic md);
        int gap;
        req_type <= rq;
        pixel <= px;
        {red, green, blue} <= col;
        {start_red, start_green, start_blue} <= first_col;
        has_start <= hs;
        step_count <= cnt;
        first_step <= fst;
        fade_mode <= md;
        start <= 1'b1;
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
        gap = ($urandom_range(0, 3) == 0) ? 0 :
              ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic random_request(input logic [7:0] px);
        logic [2:0]  rq;
        logic [15:0] cnt;
        logic [15:0] fst;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) rq = rgbfe_pkg::REQ_SET;
        else if (pick < 25) rq = rgbfe_pkg::REQ_SETUP;
        else if (pick < 32) rq = rgbfe_pkg::REQ_REVERSE;
        else if (pick < 90) rq = rgbfe_pkg::REQ_EXECUTE;
        else if (pick < 96) rq = rgbfe_pkg::REQ_READ;
        else rq = 3'($urandom_range(5, 7));
        pick = $urandom_range(0, 9);
        if (pick < 6)
        begin
            cnt = 16'($urandom_range(1, 10));
            fst = 16'($urandom_range(0, cnt - 1));
        end
        else if (pick < 8)
        begin
            cnt = 16'($urandom_range(1, 65535));
            fst = cnt - 16'($urandom_range(1, cnt < 5 ? cnt : 5));
        end
        else
        begin
            cnt = 16'($urandom);
            fst = 16'($urandom);
        end
        issue(rq, px, 24'($urandom), 24'($urandom), 1'($urandom), cnt, fst, 1'($urandom));
    endtask

    initial
    begin
        logic [7:0] px;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(rgbfe_pkg::REQ_READ, 8'd16, 24'hFFFFFF, 24'h0, 1'b0, 16'd1, 16'd0, 1'b0);
        issue(rgbfe_pkg::REQ_SET, 8'd255, 24'hFFFFFF, 24'h0, 1'b0, 16'd1, 16'd0, 1'b0);
        issue(rgbfe_pkg::REQ_REVERSE, 8'd3, 24'h0, 24'h0, 1'b0, 16'd0, 16'd0, 1'b0);
        issue(rgbfe_pkg::REQ_EXECUTE, 8'd3, 24'h0, 24'h0, 1'b0, 16'd0, 16'd0, 1'b0);
        issue(rgbfe_pkg::REQ_EXECUTE, 8'd4, 24'h0, 24'h0, 1'b0, 16'd0, 16'd0, 1'b0);
        issue(rgbfe_pkg::REQ_SET, 8'd0, 24'hFFFFFF, 24'h0, 1'b0, 16'd0, 16'd0, 1'b0);
        issue(rgbfe_pkg::REQ_SETUP, 8'd0, 24'h000000, 24'h0, 1'b0, 16'd0, 16'd0, 1'b0);
        issue(rgbfe_pkg::REQ_SETUP, 8'd0, 24'h000000, 24'h0, 1'b0, 16'd4, 16'd4, 1'b0);
        issue(rgbfe_pkg::REQ_SETUP, 8'd0, 24'h00FF00, 24'h0, 1'b0, 16'd3, 16'd0, 1'b0);
        repeat (5)
            issue(rgbfe_pkg::REQ_EXECUTE, 8'd0, 24'h0, 24'h0, 1'b0, 16'd0, 16'd0, 1'b0);
        issue(rgbfe_pkg::REQ_SETUP, 8'd15, 24'h80FF01, 24'hFF00FE, 1'b1, 16'hFFFF, 16'hFFFE,
              1'b1);
        repeat (6)
            issue(rgbfe_pkg::REQ_EXECUTE, 8'd15, 24'h0, 24'h0, 1'b0, 16'd0, 16'd0, 1'b0);
        issue(rgbfe_pkg::REQ_REVERSE, 8'd15, 24'h0, 24'h0, 1'b0, 16'd0, 16'd0, 1'b0);
        issue(3'd7, 8'd15, 24'h0, 24'h0, 1'b0, 16'd0, 16'd0, 1'b0);
        issue(rgbfe_pkg::REQ_READ, 8'd15, 24'h0, 24'h0, 1'b0, 16'd0, 16'd0, 1'b0);

        for (int i = 0; i < 1250; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                px = 8'($urandom_range(16, 255));
            else
                px = 8'($urandom_range(0, 15));
            random_request(px);
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
